>>> hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types and constants shared by the boundary edge finder files.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned VTX_W   = 3 * COORD_W;
	localparam int unsigned GEOM_W  = 3 * VTX_W;
	localparam int unsigned IDX_W   = 6;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] a_x;
		logic [COORD_W-1:0] a_y;
		logic [COORD_W-1:0] a_z;
		logic [COORD_W-1:0] b_x;
		logic [COORD_W-1:0] b_y;
		logic [COORD_W-1:0] b_z;
		logic [COORD_W-1:0] c_x;
		logic [COORD_W-1:0] c_y;
		logic [COORD_W-1:0] c_z;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] tri_index;
		logic [2:0]       open_mask;
		logic             no_triangles;
		logic             overflowed;
		logic             last;
	} out_item_t;

	// Vertex v sits at bits [v*VTX_W +: VTX_W] of a geometry word.
	typedef struct packed {
		logic              run;
		logic [GEOM_W-1:0] geom;
	} cmd_t;

endpackage

>>> hw/rtl/mbe_stream_if.sv
// ----------------------------------------------------------------------------
// mbe_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mbe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mbe_ram.sv
// ----------------------------------------------------------------------------
// mbe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mbe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hw/rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Accepts input transactions, classifies load/run, queues them (2 deep).
// ----------------------------------------------------------------------------
module mbe_front (
	input  logic          clk,
	input  logic          arst_n,
	mbe_stream_if.sink    in,
	output mbe_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);
	import mbe_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cmd_new;

	assign in.ready  = (cnt_q != 2'd2);
	assign push      = in.valid && in.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		cmd_new.run  = (in.data.func == FUNC_RUN);
		cmd_new.geom = {in.data.c_z, in.data.c_y, in.data.c_x,
		                in.data.b_z, in.data.b_y, in.data.b_x,
		                in.data.a_z, in.data.a_y, in.data.a_x};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_pop) |=> cnt_q == 2'd2) else $error("full queue changed");
endmodule

>>> hw/rtl/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back
// Executes queued commands: stores triangles, runs the pairwise edge sweep.
// ----------------------------------------------------------------------------
module mbe_back #(
	parameter int unsigned MAX_TRIANGLES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mbe_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	mbe_stream_if.source  out
);
	import mbe_pkg::*;

	localparam int unsigned AW = $clog2(MAX_TRIANGLES);
	localparam int unsigned CW = $clog2(MAX_TRIANGLES + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RDI   = 6'b000010,
		ST_LATI  = 6'b000100,
		ST_SWEEP = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              drop_q;
	logic              empty_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [GEOM_W-1:0] geom_i_q;
	logic [2:0]        shared_q;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [GEOM_W-1:0] ram_rdata;

	logic              valid_s1;
	logic              skip_s1;
	logic              valid_s2;
	logic              skip_s2;
	logic [2:0][2:0]   eq_s2;
	logic [2:0][2:0]   eq_now;
	logic [2:0]        hit;
	logic              out_free;
	logic              j_last;
	logic              i_last;
	logic              store_full;

	mbe_ram #(.WIDTH(GEOM_W), .DEPTH(MAX_TRIANGLES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (cmd.geom),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign store_full = (count_q == CW'(MAX_TRIANGLES));
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we     = cmd_pop && !cmd.run && !store_full;
	assign ram_re     = (state_q == ST_RDI) || (state_q == ST_SWEEP);
	assign ram_raddr  = (state_q == ST_RDI) ? i_q : j_q;
	assign out_free   = !out.valid || out.ready;
	assign j_last     = (CW'(j_q) + CW'(1)) == count_q;
	assign i_last     = (CW'(i_q) + CW'(1)) == count_q;

	// vertex a of triangle i against vertex b of triangle j
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				eq_now[a][b] = geom_i_q[a*VTX_W +: VTX_W] == ram_rdata[b*VTX_W +: VTX_W];
			end
		end
	end

	// edge k (k to k+1) of i appears in j as an ordered pair of distinct corners
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hit[k] = 1'b0;
			for (int p = 0; p < 3; p++) begin
				for (int q = 0; q < 3; q++) begin
					if (p != q && eq_s2[k][p] && eq_s2[(k + 1) % 3][q]) begin
						hit[k] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		eq_s2   <= eq_now;
		skip_s2 <= skip_s1;
		skip_s1 <= (j_q == i_q);
		if (state_q == ST_LATI) begin
			geom_i_q <= ram_rdata;
		end
		if (state_q == ST_EMIT && out_free) begin
			out.data.tri_index    <= empty_q ? '0 : IDX_W'(i_q);
			out.data.open_mask    <= empty_q ? 3'b000 : ~shared_q;
			out.data.no_triangles <= empty_q;
			out.data.overflowed   <= drop_q;
			out.data.last         <= empty_q || i_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			drop_q    <= 1'b0;
			empty_q   <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			shared_q  <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out.valid <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SWEEP);
			valid_s2 <= valid_s1;
			if (valid_s2 && !skip_s2) begin
				shared_q <= shared_q | hit;
			end
			// new result loads when the output is empty or its result is taken this cycle
			if (state_q == ST_EMIT && out_free) begin
				out.valid <= 1'b1;
			end else if (out.ready) begin
				out.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (!cmd.run) begin
							if (store_full) begin
								drop_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end else begin
							i_q     <= '0;
							empty_q <= (count_q == '0);
							state_q <= (count_q == '0) ? ST_EMIT : ST_RDI;
						end
					end
				end
				ST_RDI: begin
					shared_q <= '0;
					state_q  <= ST_LATI;
				end
				ST_LATI: begin
					j_q     <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					j_q <= j_q + AW'(1);
					if (j_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (empty_q || i_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= ST_RDI;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TRIANGLES)) else $error("triangle count past capacity");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !store_full) else $error("store write while full");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1)) else $error("compare stage out of order");
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !valid_s1 && !valid_s2) else $error("emit before drain");
endmodule

>>> hw/rtl/mesh_boundary_edge_finder_unit.sv
// ----------------------------------------------------------------------------
// mesh_boundary_edge_finder_unit
// Finds boundary edges of a loaded triangle set.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one transaction per command. func=0 loads a triangle (vertices
//         a, b, c, raw 96-bit each); func=1 runs extraction.
//   out : one transaction per stored triangle in load order, with a 3-bit
//         open_mask (bit k: edge k..k+1 has no partner); last marks the end.
//         An empty run gives one transaction with no_triangles set.
// Operation:
//   A load is handled in the idle state. A run over n triangles walks
//   the store once per triangle through a single read port: it reads and
//   latches triangle i, sweeps every stored j, drains, then emits a result.
//   An empty run goes straight to the emit step.
// The 2-entry command queue keeps accepting loads while the back end
// is busy; once it is full, in.ready drops.
// The output is registered; a stalled receiver holds the sweep in its
// emit step without losing or repeating a result.
// Reset clears the store count, drop flag, queue and output valid.
// Store contents are not cleared; only entries loaded since the last run
// are read.
// ----------------------------------------------------------------------------
module mesh_boundary_edge_finder_unit #(
	parameter int unsigned MAX_TRIANGLES = 64
) (
	input logic          clk,
	input logic          arst_n,
	mbe_stream_if.sink   in,
	mbe_stream_if.source out
);
	import mbe_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// front end: accept and classify
	mbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// back end: store and pairwise sweep
	mbe_back #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.out       (out)
	);
endmodule
